// ===== hdl/tshp_pkg.sv =====
// Shared types and constants of the timestamp header parser.
package tshp_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned LongW   = 64;
  localparam int unsigned ShortW  = 48;
  localparam int unsigned UsedW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned GroupW  = 2;
  localparam int unsigned ResDataW = WordW + LongW + ShortW + UsedW;

  localparam logic [HalfW-1:0] LongMarkerRst  = 16'h03e1;
  localparam logic [HalfW-1:0] ShortMarkerRst = 16'h00f7;

  // Configuration register indexes
  localparam logic RegLongMarker  = 1'b0;
  localparam logic RegShortMarker = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNone    = 2'd1;
  localparam logic [StatusW-1:0] StUnknown = 2'd2;
  localparam logic [StatusW-1:0] StTrunc   = 2'd3;

  // Group sizes modulo four, compared against the wrapped group index
  localparam logic [GroupW-1:0] ShortEnd = 2'd3;
  localparam logic [GroupW-1:0] LongEnd  = 2'd0;

  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhMark  = 5'b00010,
    PhShort = 5'b00100,
    PhLong  = 5'b01000,
    PhSep   = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [WordW-1:0]   held_id;
    logic [LongW-1:0]   long_acc;
    logic [ShortW-1:0]  short_acc;
    logic [GroupW-1:0]  group_index;
  } parse_state_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   src_id;
    logic [LongW-1:0]   long_stamp;
    logic [ShortW-1:0]  short_stamp;
    logic [UsedW-1:0]   words_used;
  } result_t;

endpackage

// ===== hdl/tshp_step.sv =====
// Next-state and result logic for one header word.
module tshp_step import tshp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  parse_state_t           cur_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  input  logic [WordW-1:0]       word_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  logic [HalfW-1:0]       long_marker_i,
  input  logic [HalfW-1:0]       short_marker_i,
  output parse_state_t           nxt_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic                   emit_o,
  output result_t                res_o
);

  logic [HalfW-1:0]         low;
  logic [HalfW-1:0]         upper;
  logic [COUNT_WIDTH-1:0]   cnt_inc;
  logic [COUNT_WIDTH+7:0]   cnt_ext;
  logic [GroupW-1:0]        gi_inc;
  logic [StatusW-1:0]       raw_status;
  logic [LongW-1:0]         long_ins;
  logic [ShortW-1:0]        short_ins;

  assign low     = word_i[HalfW-1:0];
  assign upper   = word_i[WordW-1:HalfW];
  assign cnt_inc = (cnt_i == '1) ? cnt_i : cnt_i + 1'b1;
  assign gi_inc  = cur_i.group_index + 1'b1;

  // Place the low half-word at the slot picked by the group index
  always_comb begin
    long_ins  = '0;
    short_ins = '0;
    case (cur_i.group_index)
      2'd0: begin
        long_ins[15:0]  = low;
        short_ins[15:0] = low;
      end
      2'd1: begin
        long_ins[31:16]  = low;
        short_ins[31:16] = low;
      end
      2'd2: begin
        long_ins[47:32]  = low;
        short_ins[47:32] = low;
      end
      default: begin
        long_ins[63:48] = low;
      end
    endcase
  end

  always_comb begin
    nxt_o      = cur_i;
    cnt_o      = cnt_i;
    emit_o     = 1'b0;
    raw_status = StOk;
    if (first_i) begin
      nxt_o.held_id     = word_i;
      nxt_o.long_acc    = '0;
      nxt_o.short_acc   = '0;
      nxt_o.group_index = '0;
      nxt_o.phase       = PhMark;
      cnt_o             = COUNT_WIDTH'(1);
      if (last_i) begin
        emit_o     = 1'b1;
        raw_status = StTrunc;
      end
    end else begin
      unique case (cur_i.phase)
        PhMark: begin
          cnt_o = cnt_inc;
          if (upper == short_marker_i) begin
            nxt_o.short_acc   = {{(ShortW-HalfW){1'b0}}, low};
            nxt_o.phase       = PhShort;
            nxt_o.group_index = 2'd1;
            if (last_i) begin
              emit_o     = 1'b1;
              raw_status = StTrunc;
            end
          end else if (upper == long_marker_i) begin
            nxt_o.long_acc    = {{(LongW-HalfW){1'b0}}, low};
            nxt_o.phase       = PhLong;
            nxt_o.group_index = 2'd1;
            if (last_i) begin
              emit_o     = 1'b1;
              raw_status = StTrunc;
            end
          end else begin
            emit_o     = 1'b1;
            raw_status = StUnknown;
          end
        end
        PhShort, PhLong: begin
          cnt_o = cnt_inc;
          if (cur_i.phase == PhShort) begin
            nxt_o.short_acc = cur_i.short_acc | short_ins;
          end else begin
            nxt_o.long_acc = cur_i.long_acc | long_ins;
          end
          nxt_o.group_index = gi_inc;
          if (gi_inc == ((cur_i.phase == PhShort) ? ShortEnd : LongEnd)) begin
            nxt_o.group_index = '0;
            nxt_o.phase       = PhSep;
            if (last_i) begin
              emit_o     = 1'b1;
              raw_status = StOk;
            end
          end else if (last_i) begin
            emit_o     = 1'b1;
            raw_status = StTrunc;
          end
        end
        PhSep: begin
          if (word_i == cur_i.held_id) begin
            cnt_o       = cnt_inc;
            nxt_o.phase = PhMark;
            if (last_i) begin
              emit_o     = 1'b1;
              raw_status = StTrunc;
            end
          end else begin
            // Mismatching word ends the header and is left for the payload
            emit_o     = 1'b1;
            raw_status = StOk;
          end
        end
        default: begin
          nxt_o.phase = PhIdle;
        end
      endcase
    end
    if (emit_o) begin
      nxt_o.phase = PhIdle;
    end
  end

  assign cnt_ext = {8'b0, cnt_o};

  // Resolve the final status from the updated accumulators
  always_comb begin
    res_o.src_id      = nxt_o.held_id;
    res_o.status      = raw_status;
    res_o.long_stamp  = '0;
    res_o.short_stamp = '0;
    res_o.words_used  = '0;
    if (raw_status == StOk) begin
      if ((nxt_o.long_acc != '0) || (nxt_o.short_acc != '0)) begin
        res_o.long_stamp  = nxt_o.long_acc;
        res_o.short_stamp = nxt_o.short_acc;
        res_o.words_used  = (cnt_ext > (COUNT_WIDTH+8)'(255)) ? 8'hff : cnt_ext[7:0];
      end else begin
        res_o.status = StNone;
      end
    end
  end

endmodule

// ===== hdl/timestamp_header_parser_core.sv =====
// Top level of the timestamp header parser: registers, handshakes and result stage.
//
//  channel   | direction | tdata                         | tuser       | tlast
//  ----------+-----------+-------------------------------+-------------+-----------
//  s_axis    | in        | data_word[31:0]               | first_word  | final_word
//  m_axis    | out       | src_id, long_stamp,           | status[1:0] | -
//            |           | short_stamp, words_used       |             |
//  cfg       | in        | index 0 long_marker, 1 short_marker, 16-bit data
//
// One request per clock cycle unless stalled: each word is parsed by one level of
// compare and half-word insert logic between parse state and result registers.
// A result appears on m_axis the cycle after the word that ends the header.
// s_axis_tready drops only while a result waits and m_axis_tready is low; the
// result register holds its request until it is taken.
// Reset clears the parse to idle, empties the result register and loads the
// marker registers with 0x03e1 (long) and 0x00f7 (short).
module timestamp_header_parser_core import tshp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,   // [31:0] data_word
  input  logic                s_axis_tuser,   // [0] first_word
  input  logic                s_axis_tlast,   // final_word
  // Results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] src_id, [95:32] long_stamp, [143:96] short_stamp, [151:144] words_used
  output logic [ResDataW-1:0] m_axis_tdata,
  output logic [StatusW-1:0]  m_axis_tuser,   // [1:0] status
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [HalfW-1:0]    cfg_wdata_i
);

  parse_state_t           state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [HalfW-1:0]       long_marker_q;
  logic [HalfW-1:0]       short_marker_q;
  logic                   out_valid_q;
  result_t                out_q;
  result_t                res;
  logic                   emit;
  logic                   accept;

  // Take a new word unless a result is still waiting downstream
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tshp_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cur_i          (state_q),
    .cnt_i          (count_q),
    .word_i         (s_axis_tdata),
    .first_i        (s_axis_tuser),
    .last_i         (s_axis_tlast),
    .long_marker_i  (long_marker_q),
    .short_marker_i (short_marker_q),
    .nxt_o          (state_d),
    .cnt_o          (count_d),
    .emit_o         (emit),
    .res_o          (res)
  );

  // Parse state advances only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhIdle, default: '0};
      count_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Marker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_marker_q  <= LongMarkerRst;
      short_marker_q <= ShortMarkerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLongMarker:  long_marker_q  <= cfg_wdata_i;
        RegShortMarker: short_marker_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Result register: fill on an ending word, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.words_used, out_q.short_stamp, out_q.long_stamp,
                          out_q.src_id};

endmodule

// ===== hdl/tshp_checker.sv =====
// Port-level checks for the timestamp header parser, bound to the top level.
module tshp_checker import tshp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [WordW-1:0]    s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [ResDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
      && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Any status but ok carries zero stamps and zero word count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != StOk) |-> (m_axis_tdata[ResDataW-1:WordW] == '0))
    else $error("failed result carries stamps or count");

  // Ok means at least one stamp was built
  a_ok_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StOk) |-> (m_axis_tdata[143:WordW] != '0))
    else $error("ok result without stamp");

  // A lone id word that closes the region reports a truncated header next cycle
  a_lone_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast
      |=> m_axis_tvalid && (m_axis_tuser == StTrunc)
      && (m_axis_tdata[WordW-1:0] == $past(s_axis_tdata)))
    else $error("lone id word not reported as truncated");

endmodule

bind timestamp_header_parser_core tshp_checker u_tshp_checker (.*);
